// ----- src/gcrf_pkg.sv -----
// ----------------------------------------------------------------------------
// gcrf_pkg
// Shared types, constants and helpers of the great-circle radius filter.
// ----------------------------------------------------------------------------
package gcrf_pkg;

  localparam int unsigned TRIG_ITERATIONS_DEF = 24;

  localparam int unsigned UNIT_W = 33;
  localparam int unsigned RED_W  = 36;
  localparam int unsigned TRIG_W = 34;
  localparam int unsigned PROD_W = 2 * TRIG_W;
  localparam int unsigned DIST_W = 25;
  localparam int unsigned TAG_W  = 32;

  typedef enum logic [1:0] {
    REG_REF_LAT = 2'd0,
    REG_REF_LON = 2'd1,
    REG_RADIUS  = 2'd2
  } cfg_reg_e;

  localparam logic signed [30:0]     REF_LAT_RESET = 31'sd129611159;
  localparam logic signed [31:0]     REF_LON_RESET = 32'sd776362214;
  localparam logic [DIST_W-1:0]      RADIUS_RESET  = 25'd50000;
  localparam logic [DIST_W-1:0]      MAX_DIST      = 25'd20015087;

  localparam logic signed [RED_W-1:0] FULL_TURN    = 36'sd3600000000;
  localparam logic signed [RED_W-1:0] HALF_TURN    = 36'sd1800000000;
  localparam logic signed [RED_W-1:0] QUARTER_TURN = 36'sd900000000;

  localparam logic [31:0]  PI_Q30      = 32'd3373259426;
  localparam logic [29:0]  QUARTER_U   = 30'd900000000;
  localparam logic [30:0]  HALF_U      = 31'd1800000000;
  localparam logic [63:0]  RECIP_FULL  = (64'd3373259426 << 31) / 64'd1800000000;
  localparam logic [31:0]  RECIP_U     = RECIP_FULL[31:0];
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic [61:0]  ONE_SQ      = 62'd1 << 60;
  localparam logic [22:0]  EARTH_R_M   = 23'd6371000;
  localparam logic [29:0]  HALF_Q30    = 30'd536870912;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [30:0] point_latitude;
    logic signed [31:0] point_longitude;
    logic [TAG_W-1:0]   point_tag;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_metres;
    logic              within_radius;
    logic [TAG_W-1:0]  tag_out;
  } out_t;

  function automatic logic signed [TRIG_W-1:0] atan_s(input int unsigned i);
    return $signed({2'b00, ATAN_TAB[i]});
  endfunction

  // round a q60 product back to q30
  function automatic logic signed [TRIG_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + $signed({{(PROD_W-30){1'b0}}, HALF_Q30});
    return $signed(t[TRIG_W+29:30]);
  endfunction

endpackage

// ----- src/gcrf_sincos.sv -----
// ----------------------------------------------------------------------------
// gcrf_sincos
// Pipelined angle reduction and rotation cordic: 1e-7 degree units to q30
// sine and cosine.
// ----------------------------------------------------------------------------
module gcrf_sincos #(
  parameter int unsigned Iterations = gcrf_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [gcrf_pkg::UNIT_W-1:0]  units_i,
  output logic signed [gcrf_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [gcrf_pkg::TRIG_W-1:0]  cos_o
);
  import gcrf_pkg::*;

  logic signed [RED_W-1:0] ext, mod_d, mod_q, wrap_d, wrap_q, fold, fabs;
  logic                    neg_d, neg3_q, neg4_q, neg5_q, neg6_q;
  logic                    rneg3_q, rneg4_q, rneg5_q;
  logic [29:0]             mag_q;
  logic [61:0]             p1_q, n4_q, n5_q, qd5_q, rem;
  logic [30:0]             q0, q05_q;
  logic [31:0]             q;
  logic signed [TRIG_W-1:0] zq, z6_q;

  logic signed [TRIG_W-1:0] x_q [Iterations];
  logic signed [TRIG_W-1:0] y_q [Iterations];
  logic signed [TRIG_W-1:0] z_q [Iterations];
  logic                     n_q [Iterations];

  always_comb begin
    ext = RED_W'(units_i);
    if (ext >= FULL_TURN) begin
      mod_d = ext - FULL_TURN;
    end else if (ext <= -FULL_TURN) begin
      mod_d = ext + FULL_TURN;
    end else begin
      mod_d = ext;
    end
    if (mod_q >= HALF_TURN) begin
      wrap_d = mod_q - FULL_TURN;
    end else if (mod_q < -HALF_TURN) begin
      wrap_d = mod_q + FULL_TURN;
    end else begin
      wrap_d = mod_q;
    end
    neg_d = 1'b1;
    if (wrap_q > QUARTER_TURN) begin
      fold = wrap_q - HALF_TURN;
    end else if (wrap_q < -QUARTER_TURN) begin
      fold = wrap_q + HALF_TURN;
    end else begin
      fold  = wrap_q;
      neg_d = 1'b0;
    end
    fabs = fold[RED_W-1] ? -fold : fold;
    q0   = p1_q[61:31];
    rem  = n5_q - qd5_q;
    q    = 32'(q05_q) + 32'(rem >= 62'(HALF_U));
    zq   = TRIG_W'(q);
    if (rneg5_q) begin
      zq = -zq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mod_q   <= mod_d;
      wrap_q  <= wrap_d;
      mag_q   <= fabs[29:0];
      neg3_q  <= neg_d;
      rneg3_q <= fold[RED_W-1];
      p1_q    <= mag_q * RECIP_U;
      n4_q    <= mag_q * PI_Q30 + QUARTER_U;
      neg4_q  <= neg3_q;
      rneg4_q <= rneg3_q;
      q05_q   <= q0;
      qd5_q   <= q0 * HALF_U;
      n5_q    <= n4_q;
      neg5_q  <= neg4_q;
      rneg5_q <= rneg4_q;
      z6_q    <= zq;
      neg6_q  <= neg5_q;
    end
  end

  for (genvar i = 0; i < Iterations; i++) begin : g_rot
    logic signed [TRIG_W-1:0] xin, yin, zin;
    logic                     nin;
    if (i == 0) begin : g_first
      assign xin = CORDIC_GAIN;
      assign yin = '0;
      assign zin = z6_q;
      assign nin = neg6_q;
    end else begin : g_next
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
      assign nin = n_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zin[TRIG_W-1]) begin
          x_q[i] <= xin - (yin >>> i);
          y_q[i] <= yin + (xin >>> i);
          z_q[i] <= zin - atan_s(i);
        end else begin
          x_q[i] <= xin + (yin >>> i);
          y_q[i] <= yin - (xin >>> i);
          z_q[i] <= zin + atan_s(i);
        end
        n_q[i] <= nin;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= n_q[Iterations-1] ? -y_q[Iterations-1] : y_q[Iterations-1];
      cos_o <= n_q[Iterations-1] ? -x_q[Iterations-1] : x_q[Iterations-1];
    end
  end

endmodule

// ----- src/great_circle_radius_filter.sv -----
// ----------------------------------------------------------------------------
// great_circle_radius_filter
// Great-circle distance from a configured reference point with the spherical
// law of cosines, plus an inclusive radius check.
//
//   channel   dir  handshake              payload
//   in        in   in_valid_i/in_ready_o  gcrf_pkg::in_t
//   out       out  out_valid_o/out_ready_i gcrf_pkg::out_t
//   cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// one item per cycle unless the output queue is full; the data path runs through
// the two cordic chains and the 31-step square root
// a two-entry output queue takes results; the pipeline halts only when full
// reset clears valid bits and the queue and loads the register defaults
// ----------------------------------------------------------------------------
module great_circle_radius_filter #(
  parameter int unsigned TRIG_ITERATIONS = gcrf_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gcrf_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gcrf_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i
);
  import gcrf_pkg::*;

  localparam int unsigned N  = TRIG_ITERATIONS;
  localparam int unsigned SQ = 31;
  localparam int unsigned L  = 48 + 2 * N;

  logic signed [30:0]  ref_lat_q;
  logic signed [31:0]  ref_lon_q;
  logic [DIST_W-1:0]   lim_q;

  logic                adv;
  logic [L-1:0]        vld_q;
  logic [TAG_W-1:0]    tag_q [L];

  logic signed [UNIT_W-1:0] lat0_q, rlat0_q, dlon0_q;
  logic signed [TRIG_W-1:0] sa, ca, sb, cb, cd;

  logic signed [PROD_W-1:0] pss_q, pcc_q, pccd_q;
  logic signed [TRIG_W-1:0] cd1_q, ss2_q, cc2_q, cd2_q, ss3_q;
  logic signed [34:0]       sum4;
  logic signed [31:0]       arg4_q;
  logic                     cneg5_q, cneg6_q;
  logic [30:0]              ax5_q, ax6_q;
  logic [61:0]              rad6_q;

  logic [61:0]              sv_q [SQ];
  logic [61:0]              sr_q [SQ];
  logic [30:0]              sax_q [SQ];
  logic                     sneg_q [SQ];

  logic signed [TRIG_W-1:0] vx_q [N];
  logic signed [TRIG_W-1:0] vy_q [N];
  logic signed [TRIG_W-1:0] vz_q [N];
  logic                     vneg_q [N];

  logic signed [35:0]       zf;
  logic [31:0]              ang1_q;
  logic [55:0]              prod;
  logic [DIST_W-1:0]        dist2_q, dist3_q;
  logic                     within3_q;

  out_t                     fifo_q [2];
  logic                     wr_q, rd_q;
  logic [1:0]               cnt_q;
  logic                     push, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q <= REF_LAT_RESET;
      ref_lon_q <= REF_LON_RESET;
      lim_q     <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REF_LAT: ref_lat_q <= $signed(cfg_data_i[30:0]);
        REG_REF_LON: ref_lon_q <= $signed(cfg_data_i);
        REG_RADIUS:  lim_q     <= cfg_data_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  // valid and tag travel alongside the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q[0] <= in_data_i.point_tag;
      for (int k = 1; k < L; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      lat0_q  <= UNIT_W'(in_data_i.point_latitude);
      rlat0_q <= UNIT_W'(ref_lat_q);
      dlon0_q <= UNIT_W'(in_data_i.point_longitude) - UNIT_W'(ref_lon_q);
    end
  end

  gcrf_sincos #(.Iterations(N)) u_sc_ref (
    .clk_i, .en_i(adv), .units_i(rlat0_q), .sin_o(sa), .cos_o(ca)
  );
  gcrf_sincos #(.Iterations(N)) u_sc_pt (
    .clk_i, .en_i(adv), .units_i(lat0_q), .sin_o(sb), .cos_o(cb)
  );
  gcrf_sincos #(.Iterations(N)) u_sc_dlon (
    .clk_i, .en_i(adv), .units_i(dlon0_q), .sin_o(), .cos_o(cd)
  );

  // cosine of the central angle, then 1 - c^2
  always_comb begin
    sum4 = 35'(ss3_q) + 35'(rnd_q30(pccd_q));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pss_q  <= PROD_W'(sa) * PROD_W'(sb);
      pcc_q  <= PROD_W'(ca) * PROD_W'(cb);
      cd1_q  <= cd;
      ss2_q  <= rnd_q30(pss_q);
      cc2_q  <= rnd_q30(pcc_q);
      cd2_q  <= cd1_q;
      pccd_q <= PROD_W'(cc2_q) * PROD_W'(cd2_q);
      ss3_q  <= ss2_q;
      if (sum4 > 35'(ONE_Q30)) begin
        arg4_q <= ONE_Q30;
      end else if (sum4 < -35'(ONE_Q30)) begin
        arg4_q <= -ONE_Q30;
      end else begin
        arg4_q <= sum4[31:0];
      end
      cneg5_q <= arg4_q[31];
      ax5_q   <= arg4_q[31] ? 31'(-arg4_q) : arg4_q[30:0];
      cneg6_q <= cneg5_q;
      ax6_q   <= ax5_q;
      rad6_q  <= ONE_SQ - ax5_q * ax5_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQ - 1 - j));
    logic [61:0] vin, rin, t;
    logic [30:0] axin;
    logic        nin;
    if (j == 0) begin : g_first
      assign vin  = rad6_q;
      assign rin  = '0;
      assign axin = ax6_q;
      assign nin  = cneg6_q;
    end else begin : g_next
      assign vin  = sv_q[j-1];
      assign rin  = sr_q[j-1];
      assign axin = sax_q[j-1];
      assign nin  = sneg_q[j-1];
    end
    assign t = rin + BIT;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (vin >= t) begin
          sv_q[j] <= vin - t;
          sr_q[j] <= (rin >> 1) + BIT;
        end else begin
          sv_q[j] <= vin;
          sr_q[j] <= rin >> 1;
        end
        sax_q[j]  <= axin;
        sneg_q[j] <= nin;
      end
    end
  end

  // vectoring cordic for atan2(root, |c|)
  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [TRIG_W-1:0] xin, yin, zin;
    logic                     nin;
    if (i == 0) begin : g_first
      assign xin = TRIG_W'(sax_q[SQ-1]);
      assign yin = TRIG_W'(sr_q[SQ-1]);
      assign zin = '0;
      assign nin = sneg_q[SQ-1];
    end else begin : g_next
      assign xin = vx_q[i-1];
      assign yin = vy_q[i-1];
      assign zin = vz_q[i-1];
      assign nin = vneg_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!yin[TRIG_W-1] && (yin != '0)) begin
          vx_q[i] <= xin + (yin >>> i);
          vy_q[i] <= yin - (xin >>> i);
          vz_q[i] <= zin + atan_s(i);
        end else if (yin[TRIG_W-1]) begin
          vx_q[i] <= xin - (yin >>> i);
          vy_q[i] <= yin + (xin >>> i);
          vz_q[i] <= zin - atan_s(i);
        end else begin
          vx_q[i] <= xin;
          vy_q[i] <= yin;
          vz_q[i] <= zin;
        end
        vneg_q[i] <= nin;
      end
    end
  end

  // angle to metres and the limit check
  always_comb begin
    zf = vneg_q[N-1] ? $signed({4'b0000, PI_Q30}) - 36'(vz_q[N-1]) : 36'(vz_q[N-1]);
    prod = 56'(ang1_q) * 56'(EARTH_R_M) + 56'(HALF_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (zf[35]) begin
        ang1_q <= '0;
      end else if (zf > $signed({4'b0000, PI_Q30})) begin
        ang1_q <= PI_Q30;
      end else begin
        ang1_q <= zf[31:0];
      end
      dist2_q   <= prod[54:30];
      dist3_q   <= dist2_q;
      within3_q <= (dist2_q <= lim_q);
    end
  end

  // output queue
  assign push        = adv & vld_q[L-1];
  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{distance_metres: dist3_q, within_radius: within3_q,
                        tag_out: tag_q[L-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- src/gcrf_checker.sv -----
// ----------------------------------------------------------------------------
// gcrf_checker
// Port-level checks of the great-circle radius filter, bound to the top.
// ----------------------------------------------------------------------------
module gcrf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input gcrf_pkg::out_t  out_data_o,
  input logic            cfg_we_i,
  input logic [1:0]      cfg_idx_i,
  input logic [31:0]     cfg_data_i
);
  import gcrf_pkg::*;

  logic [DIST_W-1:0] lim_q;

  // shadow of the radius limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= RADIUS_RESET;
    end else if (cfg_we_i && (cfg_idx_i == REG_RADIUS)) begin
      lim_q <= cfg_data_i[DIST_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output waiting");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.distance_metres <= MAX_DIST))
    else $error("distance beyond half circumference");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.within_radius == (out_data_o.distance_metres <= lim_q)))
    else $error("within flag disagrees with radius limit");

endmodule

bind great_circle_radius_filter gcrf_checker u_gcrf_checker (.*);
